// File: hdl/imh_pkg.sv
// imh_pkg: shared constants, codes and sequencer states for the indexed min-heap
// no dependencies; imported by indexed_min_heap
`timescale 1ns / 1ps
`default_nettype none

package imh_pkg;

    // default heap depth
    localparam int HEAP_CAPACITY = 1024;

    // fixed field widths of the item ports
    localparam int CMD_W       = 2;
    localparam int VALUE_W     = 32;
    localparam int SLOT_W      = 10;
    localparam int POS_OUT_W   = 10;
    localparam int STATUS_W    = 2;
    localparam int COUNT_OUT_W = 11;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_DELMIN = 2'd2,
        CMD_NOP    = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DEL_RD,
        S_DEL_LOAD,
        S_NOTE,
        S_UP_RD,
        S_UP_CMP,
        S_UP_E1,
        S_UP_E2,
        S_UP_END,
        S_DN_RD,
        S_DN_CMP,
        S_DN_E1,
        S_DN_E2,
        S_DN_END,
        S_DONE
    } state_t;

endpackage

`default_nettype wire

// File: hdl/indexed_min_heap.sv
// indexed_min_heap: array binary min-heap with position reporting, one command at a time
// depends on imh_pkg for widths, command and status codes and sequencer states
`timescale 1ns / 1ps
`default_nettype none

// channel | handshake          | payload                                         | per transfer
// in      | in_valid, in_stall | cmd, new_value, slot_index                      | one command
// out     | out_valid,out_stall| is_update, item_value, item_position, status,   | one update or
//         |                    | entry_count, last                               | completion item
//
// sequencing: one command at a time; an insert moves its entry up level by level, a delete
//   moves the last entry into the hole, then up or down level by level; each level is
//   read from the heap memory (two registered reads, one write port), compared and
//   swapped, and the sequencer holds during output stalls
// reset: state, fill count and output valid clear at once; the heap memory is not
//   cleared since only entries below the fill count are ever used
// stalls: each swap gives two output transfers; the sequencer holds while the output
//   register is full and stalled, input is stalled whenever a command is in progress
module indexed_min_heap #(
    parameter int CAPACITY = imh_pkg::HEAP_CAPACITY
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    // command channel
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic [imh_pkg::CMD_W-1:0]            cmd,
    input  wire logic signed [imh_pkg::VALUE_W-1:0]   new_value,
    input  wire logic [imh_pkg::SLOT_W-1:0]           slot_index,
    // result channel
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output logic                                      is_update,
    output logic signed [imh_pkg::VALUE_W-1:0]        item_value,
    output logic [imh_pkg::POS_OUT_W-1:0]             item_position,
    output logic [imh_pkg::STATUS_W-1:0]              status,
    output logic [imh_pkg::COUNT_OUT_W-1:0]           entry_count,
    output logic                                      last
);
    import imh_pkg::*;

    // heap positions, fill count, widened forms for the ports and child arithmetic
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int PW    = (IDX_W > POS_OUT_W) ? IDX_W : POS_OUT_W;
    localparam int CW    = (CNT_W > COUNT_OUT_W) ? CNT_W : COUNT_OUT_W;
    localparam int LW    = IDX_W + 2;
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    // heap memory, two registered read ports and one write port
    logic signed [VALUE_W-1:0] heap_mem [0:CAPACITY-1];
    logic signed [VALUE_W-1:0] rd_a_reg;
    logic signed [VALUE_W-1:0] rd_b_reg;
    logic [IDX_W-1:0]          rd_addr_a;
    logic [IDX_W-1:0]          rd_addr_b;
    logic                      mem_we;
    logic [IDX_W-1:0]          mem_waddr;
    logic signed [VALUE_W-1:0] mem_wdata;

    // sequencer state
    state_t                    state_reg, state_next;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic [IDX_W-1:0]          pos_reg, pos_next;
    logic [IDX_W-1:0]          child_reg, child_next;
    logic [IDX_W-1:0]          pick_reg, pick_next;
    logic                      right_ok_reg, right_ok_next;
    logic                      moved_reg, moved_next;
    logic                      ins_reg, ins_next;
    logic signed [VALUE_W-1:0] cur_reg, cur_next;
    logic signed [VALUE_W-1:0] oth_reg, oth_next;
    logic signed [VALUE_W-1:0] removed_reg, removed_next;
    status_t                   status_reg, status_next;

    // output register
    logic                      out_valid_reg, out_valid_next;
    logic                      out_upd_reg;
    logic signed [VALUE_W-1:0] out_val_reg;
    logic [POS_OUT_W-1:0]      out_pos_reg;
    status_t                   out_status_reg;
    logic [COUNT_OUT_W-1:0]    out_count_reg;
    logic                      out_last_reg;

    // item pushed into the output register this cycle
    logic                      push;
    logic                      push_upd;
    logic signed [VALUE_W-1:0] push_val;
    logic [IDX_W-1:0]          push_pos;
    logic [PW-1:0]             push_pos_ext;
    logic [CW-1:0]             count_ext;

    // address arithmetic
    logic                      accept;
    logic                      out_free;
    logic [PW-1:0]             slot_ext;
    logic [IDX_W-1:0]          del_idx;
    logic [CNT_W-1:0]          cnt_m1;
    logic [IDX_W-1:0]          par_idx;
    logic [LW-1:0]             l_ext;
    logic [LW-1:0]             r_ext;
    logic                      has_l;
    logic                      take_right;
    logic signed [VALUE_W-1:0] pick_val;

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    assign slot_ext   = PW'(slot_index);
    assign del_idx    = (cmd == CMD_DELETE) ? slot_ext[IDX_W-1:0] : '0;
    assign cnt_m1     = count_reg - 1'b1;
    assign par_idx    = IDX_W'((pos_reg - 1'b1) >> 1);
    assign l_ext      = LW'({pos_reg, 1'b1});
    assign r_ext      = l_ext + 1'b1;
    assign has_l      = l_ext < LW'(count_reg);
    // equal children pick the right one
    assign take_right = right_ok_reg && !(rd_a_reg < rd_b_reg);
    assign pick_val   = take_right ? rd_b_reg : rd_a_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    priority if (cmd == CMD_INSERT)
                        state_next = (count_reg >= CAP_CNT) ? S_DONE : S_NOTE;
                    else if (cmd == CMD_DELETE || cmd == CMD_DELMIN)
                    begin
                        if (count_reg == '0)
                            state_next = S_DONE;
                        else if (CW'(del_idx) >= CW'(count_reg) ||
                                 (cmd == CMD_DELETE && CW'(slot_ext) >= CW'(count_reg)))
                            state_next = S_DONE;
                        else
                            state_next = S_DEL_RD;
                    end
                    else
                        state_next = S_DONE;
                end
            end
            S_DEL_RD:   state_next = S_DEL_LOAD;
            S_DEL_LOAD: state_next = (CNT_W'(pos_reg) < cnt_m1) ? S_NOTE : S_DONE;
            S_NOTE:     state_next = out_free ? S_UP_RD : S_NOTE;
            S_UP_RD:    state_next = (pos_reg == '0) ? S_UP_END : S_UP_CMP;
            S_UP_CMP:   state_next = (rd_a_reg > cur_reg) ? S_UP_E1 : S_UP_END;
            S_UP_E1:    state_next = out_free ? S_UP_E2 : S_UP_E1;
            S_UP_E2:    state_next = out_free ? S_UP_RD : S_UP_E2;
            // an entry that moved up cannot also move down in a valid heap
            S_UP_END:   state_next = (ins_reg || moved_reg) ? S_DONE : S_DN_RD;
            S_DN_RD:    state_next = has_l ? S_DN_CMP : S_DN_END;
            S_DN_CMP:   state_next = (cur_reg > pick_val) ? S_DN_E1 : S_DN_END;
            S_DN_E1:    state_next = out_free ? S_DN_E2 : S_DN_E1;
            S_DN_E2:    state_next = out_free ? S_DN_RD : S_DN_E2;
            S_DN_END:   state_next = S_DONE;
            S_DONE:     state_next = out_free ? S_IDLE : S_DONE;
            default:    state_next = S_IDLE;
        endcase
    end

    // datapath, memory controls and pushes
    always_comb
    begin
        count_next    = count_reg;
        pos_next      = pos_reg;
        child_next    = child_reg;
        pick_next     = pick_reg;
        right_ok_next = right_ok_reg;
        moved_next    = moved_reg;
        ins_next      = ins_reg;
        cur_next      = cur_reg;
        oth_next      = oth_reg;
        removed_next  = removed_reg;
        status_next   = status_reg;
        rd_addr_a     = pos_reg;
        rd_addr_b     = pos_reg;
        mem_we        = 1'b0;
        mem_waddr     = pos_reg;
        mem_wdata     = cur_reg;
        push          = 1'b0;
        push_upd      = 1'b1;
        push_val      = cur_reg;
        push_pos      = pos_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    moved_next   = 1'b0;
                    removed_next = '0;
                    status_next  = ST_OK;
                    ins_next     = (cmd == CMD_INSERT);
                    cur_next     = new_value;
                    priority if (cmd == CMD_INSERT)
                    begin
                        if (count_reg >= CAP_CNT)
                            status_next = ST_FULL;
                        else
                        begin
                            pos_next   = count_reg[IDX_W-1:0];
                            count_next = count_reg + 1'b1;
                        end
                    end
                    else if (cmd == CMD_DELETE || cmd == CMD_DELMIN)
                    begin
                        pos_next = del_idx;
                        if (count_reg == '0)
                            status_next = ST_EMPTY;
                        else if (CW'(del_idx) >= CW'(count_reg) ||
                                 (cmd == CMD_DELETE && CW'(slot_ext) >= CW'(count_reg)))
                            status_next = ST_RANGE;
                    end
                    else
                        status_next = ST_OK;
                end
            end
            S_DEL_RD:
            begin
                rd_addr_a = pos_reg;
                rd_addr_b = cnt_m1[IDX_W-1:0];
            end
            S_DEL_LOAD:
            begin
                // hole at the deleted slot, the last entry travels in cur
                removed_next = rd_a_reg;
                cur_next     = rd_b_reg;
                count_next   = cnt_m1;
            end
            S_NOTE:
            begin
                push = out_free;
            end
            S_UP_RD:
            begin
                rd_addr_a = par_idx;
            end
            S_UP_CMP:
            begin
                oth_next = rd_a_reg;
            end
            S_UP_E1:
            begin
                push     = out_free;
                push_pos = par_idx;
            end
            S_UP_E2:
            begin
                push      = out_free;
                push_val  = oth_reg;
                mem_we    = out_free;
                mem_wdata = oth_reg;
                if (out_free)
                begin
                    pos_next   = par_idx;
                    moved_next = 1'b1;
                end
            end
            S_UP_END:
            begin
                mem_we = 1'b1;
            end
            S_DN_RD:
            begin
                rd_addr_a     = l_ext[IDX_W-1:0];
                rd_addr_b     = r_ext[IDX_W-1:0];
                child_next    = l_ext[IDX_W-1:0];
                right_ok_next = r_ext < LW'(count_reg);
            end
            S_DN_CMP:
            begin
                oth_next  = pick_val;
                pick_next = take_right ? child_reg + 1'b1 : child_reg;
            end
            S_DN_E1:
            begin
                push      = out_free;
                push_val  = oth_reg;
                mem_we    = out_free;
                mem_wdata = oth_reg;
            end
            S_DN_E2:
            begin
                push     = out_free;
                push_pos = pick_reg;
                if (out_free)
                    pos_next = pick_reg;
            end
            S_DN_END:
            begin
                mem_we = 1'b1;
            end
            S_DONE:
            begin
                push     = out_free;
                push_upd = 1'b0;
                push_val = removed_reg;
                push_pos = '0;
            end
            default:
            begin
                push = 1'b0;
            end
        endcase
    end

    assign out_valid_next = push || (out_valid_reg && out_stall);
    assign push_pos_ext   = PW'(push_pos);
    assign count_ext      = CW'(count_reg);

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // working registers of the current command
    always_ff @(posedge clk)
    begin
        pos_reg      <= pos_next;
        child_reg    <= child_next;
        pick_reg     <= pick_next;
        right_ok_reg <= right_ok_next;
        moved_reg    <= moved_next;
        ins_reg      <= ins_next;
        cur_reg      <= cur_next;
        oth_reg      <= oth_next;
        removed_reg  <= removed_next;
        status_reg   <= status_next;
    end

    // output payload, loaded only on a push so a stalled item holds
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            out_upd_reg    <= push_upd;
            out_val_reg    <= push_val;
            out_pos_reg    <= push_pos_ext[POS_OUT_W-1:0];
            out_status_reg <= push_upd ? ST_OK : status_reg;
            out_count_reg  <= count_ext[COUNT_OUT_W-1:0];
            out_last_reg   <= !push_upd;
        end
    end

    // heap memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
            heap_mem[mem_waddr] <= mem_wdata;
        rd_a_reg <= heap_mem[rd_addr_a];
        rd_b_reg <= heap_mem[rd_addr_b];
    end

    assign out_valid     = out_valid_reg;
    assign is_update     = out_upd_reg;
    assign item_value    = out_val_reg;
    assign item_position = out_pos_reg;
    assign status        = out_status_reg;
    assign entry_count   = out_count_reg;
    assign last          = out_last_reg;

    // fill count stays within the heap depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_CNT)
        else $error("fill count beyond capacity");

    // fill count moves by at most one entry per cycle
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (count_reg == $past(count_reg)) ||
                 (count_reg == $past(count_reg) + 1) ||
                 (count_reg + 1 == $past(count_reg)))
        else $error("fill count jumped");

    // a command transfer starts the sequencer
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg != S_IDLE))
        else $error("sequencer did not start on a command");

    // error codes only ever appear on a completion item
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != ST_OK) |-> (last && !is_update))
        else $error("error status on an update item");

endmodule

`default_nettype wire
